[rtl/p2mrf_pkg.sv]
// Package: shared constants, codes and types of the rotated mono framebuffer writer.
package p2mrf_pkg;

  // Default palette size
  localparam int PALETTE_DEPTH_DEFAULT = 256;

  // Configuration register indexes
  localparam logic [2:0] REG_PIXEL_FORMAT  = 3'd0;
  localparam logic [2:0] REG_WINDOW_X      = 3'd1;
  localparam logic [2:0] REG_WINDOW_Y      = 3'd2;
  localparam logic [2:0] REG_WINDOW_WIDTH  = 3'd3;
  localparam logic [2:0] REG_WINDOW_HEIGHT = 3'd4;
  localparam logic [2:0] REG_FB_WIDTH      = 3'd5;
  localparam logic [2:0] REG_FB_HEIGHT     = 3'd6;

  // Pixel format codes
  localparam logic [2:0] FMT_PAL1   = 3'd0;
  localparam logic [2:0] FMT_PAL4   = 3'd1;
  localparam logic [2:0] FMT_PAL8   = 3'd2;
  localparam logic [2:0] FMT_RGB555 = 3'd3;
  localparam logic [2:0] FMT_RGB24  = 3'd4;
  localparam logic [2:0] FMT_RGB32  = 3'd5;

  // Operation codes
  localparam logic OP_PALETTE_WRITE = 1'b0;
  localparam logic OP_PIXEL         = 1'b1;

  // Reset values of the registers
  localparam logic [2:0]  PIXEL_FORMAT_RESET  = FMT_RGB24;
  localparam logic [15:0] WINDOW_WIDTH_RESET  = 16'd1200;
  localparam logic [15:0] WINDOW_HEIGHT_RESET = 16'd1600;
  localparam logic [12:0] FB_WIDTH_RESET      = 13'd1200;
  localparam logic [12:0] FB_HEIGHT_RESET     = 13'd1600;

  // Luma weights and threshold
  localparam logic [6:0] LUMA_R_WEIGHT  = 7'd38;
  localparam logic [6:0] LUMA_G_WEIGHT  = 7'd75;
  localparam logic [6:0] LUMA_B_WEIGHT  = 7'd15;
  localparam logic [7:0] LUMA_THRESHOLD = 8'h80;
  localparam logic [7:0] MONO_WHITE     = 8'hf0;
  localparam logic [7:0] MONO_BLACK     = 8'h00;

  // RGB555 field masks
  localparam logic [7:0] RGB555_R_MASK  = 8'h7c;
  localparam logic [7:0] RGB555_GH_MASK = 8'h03;
  localparam logic [7:0] RGB555_GL_MASK = 8'he0;
  localparam logic [7:0] RGB555_B_MASK  = 8'h1f;

  // Pixel as it enters the shading logic
  typedef struct packed {
    logic [2:0] format;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic       palette_ok;
  } pix_t;

endpackage

[rtl/pixel_to_mono_rotated_framebuffer.sv]
// Top level: pixel/palette stream to thresholded writes of a 90-degree rotated framebuffer.
//
// Each transaction on the input is either a palette write or one pixel of the window in
// raster order. A pixel is accepted into stage one together with its palette RAM read
// (registered read) and its place on the framebuffer; in the next cycle the color is
// decoded, weighted and thresholded and the address is formed from one line-by-width
// multiply, and the result moves into the output register, raising out_valid, as soon
// as that register is free. Palette writes yield no result. The block sustains one
// transaction per clock while in_stall stays low; input stall rises only while the
// output register holds an untaken result and a pixel waits behind it. The palette
// needs no clearing after reset, so the block is ready at once.
module pixel_to_mono_rotated_framebuffer #(
  parameter int PALETTE_DEPTH = p2mrf_pkg::PALETTE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_write_enable,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [7:0]  palette_index,
  input  logic [23:0] palette_color,
  input  logic [31:0] pixel_bytes,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        write_enable,
  output logic [23:0] fb_address,
  output logic [7:0]  mono_value,
  output logic        window_end
);

  import p2mrf_pkg::*;

  localparam int ADDR_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam logic [8:0] DEPTH_LIMIT = 9'(PALETTE_DEPTH);

  // Configuration registers
  logic [2:0]  pixel_format;
  logic [15:0] window_x;
  logic [15:0] window_y;
  logic [15:0] window_width;
  logic [15:0] window_height;
  logic [12:0] fb_width;
  logic [12:0] fb_height;

  // Window counters
  logic [15:0] column_count;
  logic [15:0] row_count;
  logic [15:0] column_next;
  logic [15:0] row_next;
  logic        last_col;
  logic        last_row;

  // Handshake
  logic accept;
  logic pixel_accept;
  logic out_free;
  logic s1_advance;

  // Position of the accepted pixel
  logic [15:0] col_i;
  logic [15:0] row_j;
  logic        on_fb;

  // Stage one registers
  logic        s1_valid;
  pix_t        s1_pix;
  logic        s1_inside;
  logic [12:0] s1_line;
  logic [12:0] s1_xpos;
  logic        s1_end;

  // Palette RAM
  logic              pal_we;
  logic [23:0]       pal_rdata;
  logic [7:0]        mono;
  logic [25:0]       addr_full;

  assign out_free     = !out_valid || !out_stall;
  assign s1_advance   = s1_valid && out_free;
  assign in_stall     = s1_valid && !out_free;
  assign accept       = in_valid && !in_stall;
  assign pixel_accept = accept && (operation == OP_PIXEL);
  assign pal_we       = accept && (operation == OP_PALETTE_WRITE)
                        && ({1'b0, palette_index} < DEPTH_LIMIT);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format  <= PIXEL_FORMAT_RESET;
      window_x      <= 16'd0;
      window_y      <= 16'd0;
      window_width  <= WINDOW_WIDTH_RESET;
      window_height <= WINDOW_HEIGHT_RESET;
      fb_width      <= FB_WIDTH_RESET;
      fb_height     <= FB_HEIGHT_RESET;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        REG_PIXEL_FORMAT:  pixel_format  <= cfg_data[2:0];
        REG_WINDOW_X:      window_x      <= cfg_data;
        REG_WINDOW_Y:      window_y      <= cfg_data;
        REG_WINDOW_WIDTH:  window_width  <= cfg_data;
        REG_WINDOW_HEIGHT: window_height <= cfg_data;
        REG_FB_WIDTH:      fb_width      <= cfg_data[12:0];
        REG_FB_HEIGHT:     fb_height     <= cfg_data[12:0];
        default: begin
        end
      endcase
    end
  end

  // Advance the window counters
  assign column_next = column_count + 16'd1;
  assign row_next    = row_count + 16'd1;
  assign last_col    = (column_next == window_width);
  assign last_row    = (row_next == window_height);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= 16'd0;
      row_count    <= 16'd0;
    end else if (pixel_accept) begin
      if (last_col) begin
        column_count <= 16'd0;
        row_count    <= last_row ? 16'd0 : row_next;
      end else begin
        column_count <= column_next;
      end
    end
  end

  // Place pixel: line = column, x = fb_width - row; stored if 0 <= x < fb_width, line < fb_height
  assign col_i = window_x + column_count;
  assign row_j = window_y + row_count;
  assign on_fb = (row_j != 16'd0) && (row_j <= {3'b000, fb_width})
                 && (col_i < {3'b000, fb_height});

  // Palette store
  p2mrf_ram #(
    .WIDTH(24),
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk  (clk),
    .we   (pal_we),
    .waddr(palette_index[ADDR_W-1:0]),
    .wdata(palette_color),
    .re   (pixel_accept),
    .raddr(pixel_bytes[ADDR_W-1:0]),
    .rdata(pal_rdata)
  );

  // Stage one: hold the pixel while the palette read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixel_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_accept) begin
      s1_pix.format     <= pixel_format;
      s1_pix.byte0      <= pixel_bytes[7:0];
      s1_pix.byte1      <= pixel_bytes[15:8];
      s1_pix.byte2      <= pixel_bytes[23:16];
      s1_pix.palette_ok <= ({1'b0, pixel_bytes[7:0]} < DEPTH_LIMIT);
      s1_inside         <= on_fb;
      s1_line           <= col_i[12:0];
      s1_xpos           <= fb_width - row_j[12:0];
      s1_end            <= last_col && last_row;
    end
  end

  // Shade the pixel
  p2mrf_shade u_shade (
    .pix          (s1_pix),
    .palette_color(pal_rdata),
    .mono         (mono)
  );

  assign addr_full = s1_line * fb_width + {13'd0, s1_xpos};

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      write_enable <= s1_inside;
      fb_address   <= s1_inside ? addr_full[23:0] : 24'd0;
      mono_value   <= mono;
      window_end   <= s1_end;
    end
  end

`ifndef SYNTH
  // Input stalls only behind a waiting pixel
  assert property (@(posedge clk) disable iff (rst) in_stall |-> s1_valid)
    else $error("input stalled with empty stage one");

  // A palette write leaves the counters alone
  assert property (@(posedge clk) disable iff (rst)
    (accept && operation == OP_PALETTE_WRITE) |=>
      ($stable(column_count) && $stable(row_count)))
    else $error("palette write moved the window counters");

  // A suppressed store carries a zero address
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !write_enable) |-> (fb_address == 24'd0))
    else $error("nonzero address on suppressed store");

  // Mono value is one of the two levels
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (mono_value == MONO_WHITE || mono_value == MONO_BLACK))
    else $error("mono value off level");

  // A held stage one result reaches the output once the output frees
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_free) |=> out_valid)
    else $error("stage one result lost");
`endif

endmodule

[rtl/p2mrf_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module p2mrf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/p2mrf_shade.sv]
// Pixel decode by format, luma weighting and threshold to a mono value.
module p2mrf_shade (
  input  p2mrf_pkg::pix_t  pix,
  input  logic [23:0]      palette_color,
  output logic [7:0]       mono
);

  import p2mrf_pkg::*;

  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [14:0] luma_sum;
  logic [7:0]  luma;

  // Decode the color components
  always_comb begin
    red   = 8'd0;
    green = 8'd0;
    blue  = 8'd0;
    case (pix.format)
      FMT_PAL1, FMT_PAL4, FMT_PAL8: begin
        if (pix.palette_ok) begin
          red   = palette_color[23:16];
          green = palette_color[15:8];
          blue  = palette_color[7:0];
        end
      end
      FMT_RGB555: begin
        red   = (pix.byte0 & RGB555_R_MASK) << 1;
        green = {pix.byte0[1:0] & RGB555_GH_MASK[1:0],
                 pix.byte1[7:5] & RGB555_GL_MASK[7:5], 3'b000};
        blue  = (pix.byte1 & RGB555_B_MASK) << 3;
      end
      FMT_RGB24, FMT_RGB32: begin
        red   = pix.byte0;
        green = pix.byte1;
        blue  = pix.byte2;
      end
      default: begin
        red   = 8'd0;
        green = 8'd0;
        blue  = 8'd0;
      end
    endcase
  end

  // Weight and threshold; the sum tops out at 255 * 128
  assign luma_sum = 15'(red * LUMA_R_WEIGHT) + 15'(green * LUMA_G_WEIGHT)
                  + 15'(blue * LUMA_B_WEIGHT);
  assign luma     = luma_sum[14:7];
  assign mono     = (luma >= LUMA_THRESHOLD) ? MONO_WHITE : MONO_BLACK;

endmodule

[tb/sv/testbench.sv]
// Testbench: rotated mono framebuffer writer checked against a built-in predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import p2mrf_pkg::*;

  // Format codes the block does not define; they must shade to black
  localparam logic [2:0] FMT_UNDEF6 = 3'd6;
  localparam logic [2:0] FMT_UNDEF7 = 3'd7;

  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 135;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT   = 400000;

  // One input transaction: palette load or pixel
  typedef struct {
    logic        op;
    logic [7:0]  pidx;
    logic [23:0] pcol;
    logic [31:0] bytes;
  } feed_t;

  // One framebuffer write as it leaves the block
  typedef struct {
    logic        we;
    logic [23:0] addr;
    logic [7:0]  mono;
    logic        wend;
  } fb_write_t;

  // Register setup for one phase of the run
  typedef struct {
    logic [2:0]  fmt;
    logic [15:0] wx;
    logic [15:0] wy;
    logic [15:0] ww;
    logic [15:0] wh;
    logic [12:0] fw;
    logic [12:0] fh;
  } setup_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_enable = 1'b0;
  logic [2:0]  cfg_index = REG_PIXEL_FORMAT;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        operation = OP_PIXEL;
  logic [7:0]  palette_index = '0;
  logic [23:0] palette_color = '0;
  logic [31:0] pixel_bytes = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        write_enable;
  logic [23:0] fb_address;
  logic [7:0]  mono_value;
  logic        window_end;

  pixel_to_mono_rotated_framebuffer dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .operation        (operation),
    .palette_index    (palette_index),
    .palette_color    (palette_color),
    .pixel_bytes      (pixel_bytes),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .write_enable     (write_enable),
    .fb_address       (fb_address),
    .mono_value       (mono_value),
    .window_end       (window_end)
  );

  // Predictor copy of registers, counters and palette
  logic [2:0]  fmt_reg;
  logic [15:0] win_x, win_y, win_w, win_h;
  logic [12:0] fb_w, fb_h;
  logic [15:0] col_cnt, row_cnt;
  logic [23:0] pal_mem [256];

  // Palette entries loaded so far, as seen by the stimulus side
  bit          pal_loaded [256];
  logic [7:0]  loaded_idx [$];
  logic [7:0]  last_loaded;

  feed_t       feed_q [$];
  fb_write_t   fb_write_q [$];
  feed_t       next_item;
  fb_write_t   want;

  bit          calm_tail = 1'b0;
  int          in_gap_left = 0;
  int          out_gap_left = 0;
  int          fail_count = 0;
  int          cycle_count = 0;
  int          pixels_sent = 0;
  int          loads_sent = 0;
  int          writes_checked = 0;
  int          setups_applied = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Decode, threshold and place one pixel; load the palette on a palette write
  task automatic shade_and_rotate(input logic op, input logic [7:0] pidx,
                                  input logic [23:0] pcol, input logic [31:0] bytes);
    fb_write_t   w;
    logic [23:0] c;
    logic [15:0] col_i, row_j, nxt_col, nxt_row;
    int          r, g, b, luma, xpos;
    logic [31:0] addr;
    bit          on_fb;
    r = 0;
    g = 0;
    b = 0;
    if (op == OP_PALETTE_WRITE) begin
      pal_mem[pidx] = pcol;
    end else begin
      case (fmt_reg)
        FMT_PAL1, FMT_PAL4, FMT_PAL8: begin
          c = pal_mem[bytes[7:0]];
          r = int'(c[23:16]);
          g = int'(c[15:8]);
          b = int'(c[7:0]);
        end
        FMT_RGB555: begin
          r = int'(bytes[7:0] & RGB555_R_MASK) << 1;
          g = ((int'(bytes[7:0] & RGB555_GH_MASK) << 3) |
               (int'(bytes[15:8] & RGB555_GL_MASK) >> 5)) << 3;
          b = int'(bytes[15:8] & RGB555_B_MASK) << 3;
        end
        FMT_RGB24, FMT_RGB32: begin
          r = int'(bytes[7:0]);
          g = int'(bytes[15:8]);
          b = int'(bytes[23:16]);
        end
        default: ;
      endcase
      luma = (r * 38 + g * 75 + b * 15) >> 7;
      w.mono = (luma >= 128) ? MONO_WHITE : MONO_BLACK;

      // Screen column becomes the line, screen row mirrors into the column
      col_i = win_x + col_cnt;
      row_j = win_y + row_cnt;
      xpos = int'(fb_w) - int'(row_j);
      on_fb = (xpos >= 0) && (xpos < int'(fb_w)) && (col_i < 16'(fb_h));
      addr = 32'(int'(col_i) * int'(fb_w) + xpos);
      w.we = on_fb;
      w.addr = on_fb ? addr[23:0] : 24'd0;

      // Advance raster counters; a zero register acts as 65536
      nxt_col = col_cnt + 16'd1;
      nxt_row = row_cnt + 16'd1;
      w.wend = (nxt_col == win_w) && (nxt_row == win_h);
      if (nxt_col == win_w) begin
        col_cnt = '0;
        row_cnt = (nxt_row == win_h) ? 16'd0 : nxt_row;
      end else begin
        col_cnt = nxt_col;
      end
      fb_write_q.push_back(w);
    end
  endtask

  // Driver: present queued transactions, with random gaps between them
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        shade_and_rotate(operation, palette_index, palette_color, pixel_bytes);
      end
      if (!in_valid || !in_stall) begin
        if (in_gap_left > 0 && !calm_tail) begin
          in_valid <= 1'b0;
          in_gap_left--;
        end else if (feed_q.size() != 0) begin
          next_item = feed_q.pop_front();
          operation <= next_item.op;
          palette_index <= next_item.pidx;
          palette_color <= next_item.pcol;
          pixel_bytes <= next_item.bytes;
          in_valid <= 1'b1;
          if (!calm_tail && $urandom_range(0, 9) == 0) in_gap_left = $urandom_range(1, 17);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each taken framebuffer write and stall in random bursts
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (fb_write_q.size() == 0) begin
        $error("framebuffer write with nothing expected: write_enable=%0b fb_address=%h",
               write_enable, fb_address);
        fail_count++;
      end else begin
        want = fb_write_q.pop_front();
        writes_checked++;
        if (write_enable !== want.we) begin
          $error("write_enable: expected %0b, got %0b", want.we, write_enable);
          fail_count++;
        end
        if (fb_address !== want.addr) begin
          $error("fb_address: expected %h, got %h", want.addr, fb_address);
          fail_count++;
        end
        if (mono_value !== want.mono) begin
          $error("mono_value: expected %h, got %h", want.mono, mono_value);
          fail_count++;
        end
        if (window_end !== want.wend) begin
          $error("window_end: expected %0b, got %0b", want.wend, window_end);
          fail_count++;
        end
      end
    end
    if (out_gap_left > 0 && !calm_tail) begin
      out_stall <= 1'b1;
      out_gap_left--;
    end else if (!calm_tail && $urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      out_gap_left = $urandom_range(0, 16);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic reset_predictor();
    fmt_reg = PIXEL_FORMAT_RESET;
    win_x = '0;
    win_y = '0;
    win_w = WINDOW_WIDTH_RESET;
    win_h = WINDOW_HEIGHT_RESET;
    fb_w = FB_WIDTH_RESET;
    fb_h = FB_HEIGHT_RESET;
    col_cnt = '0;
    row_cnt = '0;
  endtask

  // Drive one register write and mirror it in the predictor
  task automatic program_reg(input logic [2:0] idx, input logic [15:0] data);
    @(posedge clk);
    cfg_write_enable <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_PIXEL_FORMAT:  fmt_reg = data[2:0];
      REG_WINDOW_X:      win_x = data;
      REG_WINDOW_Y:      win_y = data;
      REG_WINDOW_WIDTH:  win_w = data;
      REG_WINDOW_HEIGHT: win_h = data;
      REG_FB_WIDTH:      fb_w = data[12:0];
      REG_FB_HEIGHT:     fb_h = data[12:0];
      default: ;
    endcase
  endtask

  task automatic end_reg_writes();
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    @(negedge clk);
  endtask

  // Hold until every transaction is taken and every write has come out
  task automatic wait_idle();
    @(negedge clk);
    while (feed_q.size() != 0 || in_valid || fb_write_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic feed_t palette_item(input logic [7:0] idx, input logic [23:0] color);
    feed_t it;
    it.op = OP_PALETTE_WRITE;
    it.pidx = idx;
    it.pcol = color;
    it.bytes = $urandom;
    if (!pal_loaded[idx]) loaded_idx.push_back(idx);
    pal_loaded[idx] = 1'b1;
    last_loaded = idx;
    return it;
  endfunction

  function automatic feed_t pixel_item(input logic [31:0] bytes);
    feed_t it;
    it.op = OP_PIXEL;
    it.pidx = 8'($urandom);
    it.pcol = 24'($urandom);
    it.bytes = bytes;
    return it;
  endfunction

  // Random pixel; in palette formats, once entries are loaded, it only indexes loaded ones
  function automatic feed_t random_pixel();
    feed_t it;
    it = pixel_item($urandom);
    if ((fmt_reg == FMT_PAL1 || fmt_reg == FMT_PAL4 || fmt_reg == FMT_PAL8) &&
        loaded_idx.size() != 0) begin
      if ($urandom_range(0, 3) == 0) it.bytes[7:0] = last_loaded;
      else it.bytes[7:0] = loaded_idx[$urandom_range(0, loaded_idx.size() - 1)];
    end
    return it;
  endfunction

  task automatic queue_item(input feed_t it);
    feed_q.push_back(it);
    if (it.op == OP_PIXEL) pixels_sent++;
    else loads_sent++;
  endtask

  // Bring counters back to the window origin by making the next pixel the last one
  task automatic close_window();
    if (col_cnt != 0 || row_cnt != 0) begin
      program_reg(REG_WINDOW_WIDTH, col_cnt + 16'd1);
      program_reg(REG_WINDOW_HEIGHT, row_cnt + 16'd1);
      end_reg_writes();
      queue_item(random_pixel());
      wait_idle();
    end
  endtask

  task automatic apply_setup(input setup_t s);
    if (s.ww != win_w || s.wh != win_h) close_window();
    program_reg(REG_PIXEL_FORMAT, 16'(s.fmt));
    program_reg(REG_WINDOW_X, s.wx);
    program_reg(REG_WINDOW_Y, s.wy);
    program_reg(REG_WINDOW_WIDTH, s.ww);
    program_reg(REG_WINDOW_HEIGHT, s.wh);
    program_reg(REG_FB_WIDTH, 16'(s.fw));
    program_reg(REG_FB_HEIGHT, 16'(s.fh));
    end_reg_writes();
    setups_applied++;
  endtask

  // Mostly small windows straddling the framebuffer edges, with a few extremes
  function automatic setup_t pick_setup(input int p);
    setup_t s;
    s.fmt = (p < 8) ? 3'(p) : 3'($urandom_range(0, 7));
    s.ww = 16'($urandom_range(1, 8));
    s.wh = 16'($urandom_range(1, 6));
    s.fw = 13'($urandom_range(1, 20));
    s.fh = 13'($urandom_range(1, 20));
    s.wy = 16'(int'(s.fw) - int'($urandom_range(0, int'(s.wh) + 1)));
    s.wx = 16'(int'(s.fh) - int'($urandom_range(0, int'(s.ww) + 1)));
    if ($urandom_range(0, 3) == 0) begin
      s.wx = 16'($urandom_range(0, 3));
      s.wy = 16'($urandom);
    end
    case (p)
      2: begin
        s.fw = 13'd4096; s.fh = 13'd4096; s.ww = 16'd3; s.wh = 16'd4;
        s.wx = 16'd4093; s.wy = 16'd4094;
      end
      5: begin
        s.fw = 13'd1; s.fh = 13'd1; s.ww = 16'd1; s.wh = 16'd1;
        s.wx = 16'd0; s.wy = 16'd1;
      end
      7: begin
        s.fh = 13'd4; s.ww = 16'd2; s.wh = 16'hffff;
        s.wx = 16'hffff; s.wy = 16'hfffe;
      end
      9: begin
        s.fw = 13'h1fff; s.fh = 13'h1fff; s.ww = 16'hffff; s.wh = 16'd1;
        s.wx = 16'd8100; s.wy = 16'd1;
      end
      10: begin
        s.fw = 13'd0; s.fh = 13'd0; s.ww = 16'd0; s.wh = 16'd0;
        s.wx = 16'd0; s.wy = 16'd0;
      end
      default: ;
    endcase
    return s;
  endfunction

  initial begin
    reset_predictor();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Default registers: the first pixel lands just outside the framebuffer
    queue_item(pixel_item(32'hffff_ffff));
    queue_item(pixel_item(32'h0000_0000));
    wait_idle();

    // Direct color: threshold edges, all-ones and all-zeros, palette loads at extremes
    apply_setup('{FMT_RGB24, 16'd1, 16'd0, 16'd2, 16'd2, 13'd2, 13'd2});
    queue_item(palette_item(8'h00, 24'hffffff));
    queue_item(palette_item(8'hff, 24'h000000));
    queue_item(palette_item(8'h5a, 24'h808080));
    queue_item(palette_item(8'ha5, 24'h7f7f7f));
    queue_item(pixel_item(32'h0080_8080));
    queue_item(pixel_item(32'h007f_7f7f));
    queue_item(pixel_item(32'hffff_ffff));
    queue_item(pixel_item(32'h0000_0000));
    wait_idle();

    apply_setup('{FMT_RGB555, 16'd1, 16'd0, 16'd2, 16'd2, 13'd2, 13'd2});
    queue_item(pixel_item(32'h0000_ffff));
    queue_item(pixel_item(32'hffff_0000));
    wait_idle();

    // Palette: load then read the same entry back to back
    apply_setup('{FMT_PAL8, 16'd1, 16'd0, 16'd2, 16'd2, 13'd2, 13'd2});
    queue_item(palette_item(8'h33, 24'hffffff));
    queue_item(pixel_item(32'h0000_0033));
    queue_item(pixel_item(32'hffff_ffff));
    queue_item(pixel_item(32'h0000_0000));
    wait_idle();

    // Undefined formats shade to black but still move the counters
    apply_setup('{FMT_UNDEF6, 16'd1, 16'd0, 16'd2, 16'd2, 13'd2, 13'd2});
    queue_item(pixel_item(32'hffff_ffff));
    wait_idle();
    apply_setup('{FMT_UNDEF7, 16'd1, 16'd0, 16'd2, 16'd2, 13'd2, 13'd2});
    queue_item(pixel_item(32'hffff_ffff));
    wait_idle();

    // Random phases; the last one runs with no gaps and no stalls
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      apply_setup(pick_setup(p));
      if (p == RANDOM_PHASES - 1) calm_tail = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 99) < 15) queue_item(palette_item(8'($urandom), 24'($urandom)));
        else queue_item(random_pixel());
      end
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (fb_write_q.size() != 0) begin
      $error("%0d framebuffer writes never arrived", fb_write_q.size());
      fail_count++;
    end
    $display("Sent %0d pixels and %0d palette loads, checked %0d framebuffer writes",
             pixels_sent, loads_sent, writes_checked);
    $display("Used %0d register setups: all format codes, clipped stores, counter wrap",
             setups_applied);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
